@@ hw/rtl/fqes_pkg.sv @@
// Shared constants, types and helpers for the finite-queue event simulator.
`timescale 1ns / 1ps
package fqes_pkg;

	localparam int TimeW      = 48;
	localparam int SampleW    = 32;
	localparam int CapW       = 4;
	localparam int DepW       = 24;
	localparam int RejW       = 32;
	localparam int KindW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 48;
	localparam int CapCmpW    = 8;

	localparam int TimeFracBits = 16;
	localparam int MaxCapacity  = 15;

	localparam logic [CapW-1:0]  CapacityRst = CapW'(3);
	localparam logic [TimeW-1:0] StopTimeRst = TimeW'(64'd200000 << TimeFracBits);
	localparam logic [DepW-1:0]  MaxDepRst   = DepW'(999999);

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_STOP_TIME = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_DEP   = 2'd2;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef enum logic [KindW-1:0] {
		EV_ADMIT    = 2'd0,
		EV_REJECT   = 2'd1,
		EV_COMPLETE = 2'd2,
		EV_NONE     = 2'd3
	} event_kind_t;

	function automatic logic [TimeW-1:0] sat_add_time(input logic [TimeW-1:0] a,
			input logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			sat_add_time = s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
		end
	endfunction

endpackage

@@ hw/rtl/finite_queue_event_simulator_unit.sv @@
// Top level: single-server finite-capacity queue, one simulation event per transaction.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, interarrival,         | sink
//          | service_sample                                 |
//  out     | out_valid, out_stall, event_kind ... run_done  | source
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata                | sink
//
// An input transaction is held in the input register, then the event logic updates the
// state and loads the result register at the same edge; one transaction per cycle is
// sustained while the result is not stalled. The state feedback through that one stage
// sets the rate. Reset clears the run state and loads the register defaults; a step
// before any start reports no event. A stalled result holds its register; the input
// register still takes one more transaction behind it.
`timescale 1ns / 1ps
module finite_queue_event_simulator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [fqes_pkg::SampleW-1:0]    interarrival,
	input  logic [fqes_pkg::SampleW-1:0]    service_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fqes_pkg::KindW-1:0]      event_kind,
	output logic [fqes_pkg::TimeW-1:0]      clock_now,
	output logic [fqes_pkg::CapW-1:0]       jobs_in_node,
	output logic [fqes_pkg::DepW-1:0]       departed_count,
	output logic [fqes_pkg::RejW-1:0]       rejected_count,
	output logic [fqes_pkg::TimeW-1:0]      area_node,
	output logic [fqes_pkg::TimeW-1:0]      area_queue,
	output logic [fqes_pkg::TimeW-1:0]      area_busy,
	output logic [fqes_pkg::TimeW-1:0]      last_arrival_time,
	output logic                            run_done,
	input  logic                            cfg_wr_en,
	input  logic [fqes_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [fqes_pkg::CfgDataW-1:0]   cfg_wdata
);
	import fqes_pkg::*;

	localparam int ProdW = TimeW + CapW;

	// configuration
	logic [CapW-1:0]  cfg_cap_q;
	logic [TimeW-1:0] cfg_stop_q;
	logic [DepW-1:0]  cfg_maxdep_q;

	// input stage
	logic               valid_s1;
	logic               cmd_s1;
	logic [SampleW-1:0] inter_s1;
	logic [SampleW-1:0] serv_s1;

	// simulation state
	logic [TimeW-1:0] clk_q, at_q, ct_q, node_q, queue_q, busy_q, last_q;
	logic             ap_q, cp_q;
	logic [CapW-1:0]  occ_q;
	logic [DepW-1:0]  dep_q;
	logic [RejW-1:0]  rej_q;

	// result register
	logic             out_valid_q;
	event_kind_t      out_kind_q;
	logic [TimeW-1:0] out_clk_q, out_node_q, out_queue_q, out_busy_q, out_last_q;
	logic [CapW-1:0]  out_occ_q;
	logic [DepW-1:0]  out_dep_q;
	logic [RejW-1:0]  out_rej_q;
	logic             out_done_q;

	// next-state
	logic [TimeW-1:0] n_clk, n_at, n_ct, n_node, n_queue, n_busy, n_last;
	logic             n_ap, n_cp;
	logic [CapW-1:0]  n_occ;
	logic [DepW-1:0]  n_dep;
	logic [RejW-1:0]  n_rej;
	event_kind_t      n_kind;
	logic             n_done;

	logic               advance, fire, accept;
	logic               done_cur, take_arr;
	logic [TimeW-1:0]   next_t, dt;
	logic [ProdW-1:0]   prod_node, prod_queue;
	logic [TimeW-1:0]   inc_node, inc_queue;
	logic [CapCmpW-1:0] cap_eff;
	logic [CapW-1:0]    occ_dec;
	logic [TimeW-1:0]   inter_ext, serv_ext;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign inter_ext = TimeW'(inter_s1);
	assign serv_ext  = TimeW'(serv_s1);

	assign done_cur = (!(ap_q && (at_q < cfg_stop_q)) && (occ_q == '0))
		|| (dep_q >= cfg_maxdep_q);
	assign take_arr = ap_q && (!cp_q || (at_q <= ct_q));
	assign next_t   = take_arr ? at_q : ct_q;
	assign dt       = (next_t > clk_q) ? (next_t - clk_q) : '0;

	assign prod_node  = ProdW'(dt) * ProdW'(occ_q);
	assign prod_queue = ProdW'(dt) * ProdW'(occ_q - CapW'(1));
	assign inc_node   = (prod_node[ProdW-1:TimeW] != '0) ? {TimeW{1'b1}}
		: prod_node[TimeW-1:0];
	assign inc_queue  = (prod_queue[ProdW-1:TimeW] != '0) ? {TimeW{1'b1}}
		: prod_queue[TimeW-1:0];

	assign cap_eff = ({{(CapCmpW-CapW){1'b0}}, cfg_cap_q} > CapCmpW'(MaxCapacity))
		? CapCmpW'(MaxCapacity) : {{(CapCmpW-CapW){1'b0}}, cfg_cap_q};
	assign occ_dec = (occ_q != '0) ? (occ_q - CapW'(1)) : '0;

	always_comb begin
		n_clk   = clk_q;
		n_at    = at_q;
		n_ap    = ap_q;
		n_ct    = ct_q;
		n_cp    = cp_q;
		n_occ   = occ_q;
		n_dep   = dep_q;
		n_rej   = rej_q;
		n_node  = node_q;
		n_queue = queue_q;
		n_busy  = busy_q;
		n_last  = last_q;
		n_kind  = EV_NONE;
		if (cmd_s1 == CMD_START) begin
			n_clk   = '0;
			n_occ   = '0;
			n_dep   = '0;
			n_rej   = '0;
			n_node  = '0;
			n_queue = '0;
			n_busy  = '0;
			n_last  = '0;
			n_ct    = '0;
			n_cp    = 1'b0;
			n_at    = inter_ext;
			n_ap    = 1'b1;
		end else if (!done_cur && (ap_q || cp_q)) begin
			if (occ_q != '0) begin
				n_node  = sat_add_time(node_q, inc_node);
				n_queue = sat_add_time(queue_q, inc_queue);
				n_busy  = sat_add_time(busy_q, dt);
			end
			n_clk = next_t;
			if (take_arr) begin
				if ({{(CapCmpW-CapW){1'b0}}, occ_q} < cap_eff) begin
					n_occ  = occ_q + CapW'(1);
					n_last = next_t;
					if (occ_q == '0) begin
						n_ct = sat_add_time(next_t, serv_ext);
						n_cp = 1'b1;
					end
					n_kind = EV_ADMIT;
				end else begin
					if (rej_q != '1)
						n_rej = rej_q + RejW'(1);
					n_kind = EV_REJECT;
				end
				n_at = sat_add_time(at_q, inter_ext);
				if (n_at > cfg_stop_q)
					n_ap = 1'b0;
			end else begin
				if (dep_q != '1)
					n_dep = dep_q + DepW'(1);
				n_occ = occ_dec;
				if (occ_dec != '0) begin
					n_ct = sat_add_time(next_t, serv_ext);
					n_cp = 1'b1;
				end else begin
					n_cp = 1'b0;
				end
				n_kind = EV_COMPLETE;
			end
		end
		n_done = (!(n_ap && (n_at < cfg_stop_q)) && (n_occ == '0))
			|| (n_dep >= cfg_maxdep_q);
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cap_q    <= CapacityRst;
			cfg_stop_q   <= StopTimeRst;
			cfg_maxdep_q <= MaxDepRst;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			clk_q        <= '0;
			at_q         <= '0;
			ap_q         <= 1'b0;
			ct_q         <= '0;
			cp_q         <= 1'b0;
			occ_q        <= '0;
			dep_q        <= '0;
			rej_q        <= '0;
			node_q       <= '0;
			queue_q      <= '0;
			busy_q       <= '0;
			last_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CAPACITY:  cfg_cap_q    <= cfg_wdata[CapW-1:0];
					CFG_STOP_TIME: cfg_stop_q   <= cfg_wdata[TimeW-1:0];
					CFG_MAX_DEP:   cfg_maxdep_q <= cfg_wdata[DepW-1:0];
					default: ;
				endcase
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= valid_s1;
			if (fire) begin
				clk_q   <= n_clk;
				at_q    <= n_at;
				ap_q    <= n_ap;
				ct_q    <= n_ct;
				cp_q    <= n_cp;
				occ_q   <= n_occ;
				dep_q   <= n_dep;
				rej_q   <= n_rej;
				node_q  <= n_node;
				queue_q <= n_queue;
				busy_q  <= n_busy;
				last_q  <= n_last;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			inter_s1 <= interarrival;
			serv_s1  <= service_sample;
		end
		if (fire) begin
			out_kind_q  <= n_kind;
			out_clk_q   <= n_clk;
			out_occ_q   <= n_occ;
			out_dep_q   <= n_dep;
			out_rej_q   <= n_rej;
			out_node_q  <= n_node;
			out_queue_q <= n_queue;
			out_busy_q  <= n_busy;
			out_last_q  <= n_last;
			out_done_q  <= n_done;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_kind        = out_kind_q;
	assign clock_now         = out_clk_q;
	assign jobs_in_node      = out_occ_q;
	assign departed_count    = out_dep_q;
	assign rejected_count    = out_rej_q;
	assign area_node         = out_node_q;
	assign area_queue        = out_queue_q;
	assign area_busy         = out_busy_q;
	assign last_arrival_time = out_last_q;
	assign run_done          = out_done_q;

`ifndef SYNTHESIS
	// a job is in service exactly when the node is not empty
	a_busy_matches_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cp_q == (occ_q != '0)) else $error("completion pending disagrees with occupancy");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1 == CMD_START) |=> (occ_q == '0) && (clk_q == '0) && ap_q)
		else $error("start transaction did not reset the run");

	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1 == CMD_STEP) |=> clk_q >= $past(clk_q))
		else $error("simulation clock went back");

	a_fire_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q) else $error("event result lost");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule
